@@ rtl/tfd_pkg.sv @@
package tfd_pkg;

    // parse phases of one packet
    typedef enum logic [3:0] {
        PH_OP_HI,
        PH_OP_LO,
        PH_SIZE_HI,
        PH_SIZE_LO,
        PH_DBLK_HI,
        PH_DBLK_LO,
        PH_PAYLOAD,
        PH_ABLK_HI,
        PH_ABLK_LO,
        PH_CODE_HI,
        PH_CODE_LO,
        PH_MSG,
        PH_FLAG,
        PH_NAME
    } t_phase;

    // opcodes on the wire
    localparam logic [15:0] OP_DATA  = 16'd3;
    localparam logic [15:0] OP_ACK   = 16'd4;
    localparam logic [15:0] OP_ERROR = 16'd5;
    localparam logic [15:0] OP_BCAST = 16'd9;

    // broadcast flag value for an added file, string terminator
    localparam logic [7:0] FLAG_ADDED = 8'd1;
    localparam logic [7:0] CHAR_NUL   = 8'd0;

    // packet type codes
    localparam logic [2:0] TYPE_DATA    = 3'd0;
    localparam logic [2:0] TYPE_ACK     = 3'd1;
    localparam logic [2:0] TYPE_ERROR   = 3'd2;
    localparam logic [2:0] TYPE_BCAST   = 3'd3;
    localparam logic [2:0] TYPE_UNKNOWN = 3'd4;

    // event kinds
    localparam logic EV_BYTE = 1'b0;
    localparam logic EV_DONE = 1'b1;

    // one parse step's result
    typedef struct packed {
        logic        has_result;
        logic [2:0]  packet_type;
        logic        event_kind;
        logic [7:0]  payload_byte;
        logic [15:0] block_number;
        logic [15:0] payload_length;
        logic [15:0] err_code;
        logic        bcast_added;
        logic        end_of_packet;
    } t_result;

endpackage

@@ rtl/tftp_packet_deframer.sv @@
// TFTP receive deframer: parses a byte stream into data, ack, error and
// broadcast packets.
// input channel: i_valid / o_ready with i_rx_byte, one byte per request.
// output channel: o_valid / i_ready with the result fields; a byte yields
// zero or one result (payload or filename byte, or packet completion).
// a byte taken is held in the input register and parsed from there; its
// result is then registered in the result register, which offers it.
// throughput is one byte per cycle while the result register is free or
// being emptied: one input register and one result register, with the
// combinational header decode between them.
// when the receiver stalls, the result register holds and the input
// register fills; o_ready then drops until the result is taken.
// bytes that produce no result pass through without waiting on i_ready
// only when the result register is free or being emptied.
// reset (synchronous, active low) empties both registers and returns the
// parser to waiting for the opcode high byte.
module tftp_packet_deframer import tfd_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_rx_byte,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [2:0]  o_packet_type,
    output logic        o_event_kind,
    output logic [7:0]  o_payload_byte,
    output logic [15:0] o_block_number,
    output logic [15:0] o_payload_length,
    output logic [15:0] o_err_code,
    output logic        o_bcast_added,
    output logic        o_end_of_packet
);

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_out_valid;
    t_result    r_out;
    logic       s_advance;
    t_result    s_result;

    // input byte moves into the parser when the result slot is free or being emptied
    assign s_advance = r_in_valid && (!r_out_valid || i_ready);
    assign o_ready   = !r_in_valid || s_advance;

    tfd_parser u_parser (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (s_advance),
        .i_byte   (r_in_byte),
        .o_result (s_result)
    );

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_in_byte <= i_rx_byte;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s_advance) begin
            r_out_valid <= s_result.has_result;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_advance && s_result.has_result) begin
            r_out <= s_result;
        end
    end

    // output ports
    assign o_valid          = r_out_valid;
    assign o_packet_type    = r_out.packet_type;
    assign o_event_kind     = r_out.event_kind;
    assign o_payload_byte   = r_out.payload_byte;
    assign o_block_number   = r_out.block_number;
    assign o_payload_length = r_out.payload_length;
    assign o_err_code       = r_out.err_code;
    assign o_bcast_added    = r_out.bcast_added;
    assign o_end_of_packet  = r_out.end_of_packet;

endmodule

@@ rtl/tfd_parser.sv @@
module tfd_parser import tfd_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_step,
    input  logic [7:0] i_byte,
    output t_result    o_result
);

    t_phase      r_phase, n_phase;
    logic [7:0]  r_hold, n_hold;
    logic [15:0] r_length, n_length;
    logic [15:0] r_remaining, n_remaining;
    logic [15:0] r_block, n_block;
    logic [15:0] r_code, n_code;
    logic        r_add, n_add;

    logic [15:0] s_word;
    logic [15:0] s_rem_dec;
    logic        s_last;

    assign s_word    = {r_hold, i_byte};
    assign s_rem_dec = r_remaining - 16'd1;
    assign s_last    = (s_rem_dec == 16'd0);

    // next phase
    always_comb begin
        n_phase = r_phase;
        case (r_phase)
            PH_OP_HI:   n_phase = PH_OP_LO;
            PH_OP_LO: begin
                case (s_word)
                    OP_DATA:  n_phase = PH_SIZE_HI;
                    OP_ACK:   n_phase = PH_ABLK_HI;
                    OP_ERROR: n_phase = PH_CODE_HI;
                    OP_BCAST: n_phase = PH_FLAG;
                    default:  n_phase = PH_OP_HI;
                endcase
            end
            PH_SIZE_HI: n_phase = PH_SIZE_LO;
            PH_SIZE_LO: n_phase = PH_DBLK_HI;
            PH_DBLK_HI: n_phase = PH_DBLK_LO;
            PH_DBLK_LO: n_phase = (r_length == 16'd0) ? PH_OP_HI : PH_PAYLOAD;
            PH_PAYLOAD: n_phase = s_last ? PH_OP_HI : PH_PAYLOAD;
            PH_ABLK_HI: n_phase = PH_ABLK_LO;
            PH_ABLK_LO: n_phase = PH_OP_HI;
            PH_CODE_HI: n_phase = PH_CODE_LO;
            PH_CODE_LO: n_phase = PH_MSG;
            PH_MSG:     n_phase = (i_byte == CHAR_NUL) ? PH_OP_HI : PH_MSG;
            PH_FLAG:    n_phase = PH_NAME;
            PH_NAME:    n_phase = (i_byte == CHAR_NUL) ? PH_OP_HI : PH_NAME;
            default:    n_phase = PH_OP_HI;
        endcase
    end

    // header field capture
    always_comb begin
        n_hold      = r_hold;
        n_length    = r_length;
        n_remaining = r_remaining;
        n_block     = r_block;
        n_code      = r_code;
        n_add       = r_add;
        case (r_phase)
            PH_OP_HI, PH_SIZE_HI, PH_DBLK_HI, PH_ABLK_HI, PH_CODE_HI: begin
                n_hold = i_byte;
            end
            PH_SIZE_LO: n_length = s_word;
            PH_DBLK_LO: begin
                n_block     = s_word;
                n_remaining = r_length;
            end
            PH_PAYLOAD: n_remaining = s_rem_dec;
            PH_ABLK_LO: n_block = s_word;
            PH_CODE_LO: n_code = s_word;
            PH_FLAG:    n_add = (i_byte == FLAG_ADDED);
            default: begin
            end
        endcase
    end

    // result of this byte
    always_comb begin
        o_result = '0;
        case (r_phase)
            PH_OP_LO: begin
                if (s_word != OP_DATA && s_word != OP_ACK &&
                    s_word != OP_ERROR && s_word != OP_BCAST) begin
                    o_result.has_result    = 1'b1;
                    o_result.packet_type   = TYPE_UNKNOWN;
                    o_result.event_kind    = EV_DONE;
                    o_result.end_of_packet = 1'b1;
                end
            end
            PH_DBLK_LO: begin
                if (r_length == 16'd0) begin
                    o_result.has_result    = 1'b1;
                    o_result.packet_type   = TYPE_DATA;
                    o_result.event_kind    = EV_DONE;
                    o_result.block_number  = s_word;
                    o_result.end_of_packet = 1'b1;
                end
            end
            PH_PAYLOAD: begin
                o_result.has_result     = 1'b1;
                o_result.packet_type    = TYPE_DATA;
                o_result.event_kind     = EV_BYTE;
                o_result.payload_byte   = i_byte;
                o_result.block_number   = r_block;
                o_result.payload_length = r_length;
                o_result.end_of_packet  = s_last;
            end
            PH_ABLK_LO: begin
                o_result.has_result    = 1'b1;
                o_result.packet_type   = TYPE_ACK;
                o_result.event_kind    = EV_DONE;
                o_result.block_number  = s_word;
                o_result.end_of_packet = 1'b1;
            end
            PH_MSG: begin
                if (i_byte == CHAR_NUL) begin
                    o_result.has_result    = 1'b1;
                    o_result.packet_type   = TYPE_ERROR;
                    o_result.event_kind    = EV_DONE;
                    o_result.err_code      = r_code;
                    o_result.end_of_packet = 1'b1;
                end
            end
            PH_NAME: begin
                o_result.has_result  = 1'b1;
                o_result.packet_type = TYPE_BCAST;
                o_result.bcast_added = r_add;
                if (i_byte == CHAR_NUL) begin
                    o_result.event_kind    = EV_DONE;
                    o_result.end_of_packet = 1'b1;
                end else begin
                    o_result.event_kind   = EV_BYTE;
                    o_result.payload_byte = i_byte;
                end
            end
            default: begin
            end
        endcase
    end

    // state registers, advanced once per byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_OP_HI;
            r_hold      <= '0;
            r_length    <= '0;
            r_remaining <= '0;
            r_block     <= '0;
            r_code      <= '0;
            r_add       <= 1'b0;
        end else if (i_step) begin
            r_phase     <= n_phase;
            r_hold      <= n_hold;
            r_length    <= n_length;
            r_remaining <= n_remaining;
            r_block     <= n_block;
            r_code      <= n_code;
            r_add       <= n_add;
        end
    end

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 100ps

module testbench import tfd_pkg::*; ();

    localparam int CLK_HALF       = 4;
    localparam int RESET_CYCLES   = 5;
    localparam int LONG_STALL     = 300;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 8;

    logic        i_clk     = 1'b0;
    logic        i_rst_n   = 1'b0;
    logic        i_valid   = 1'b0;
    logic [7:0]  i_rx_byte = 8'h00;
    logic        i_ready   = 1'b0;
    logic        o_ready;
    logic        o_valid;
    logic [2:0]  o_packet_type;
    logic        o_event_kind;
    logic [7:0]  o_payload_byte;
    logic [15:0] o_block_number;
    logic [15:0] o_payload_length;
    logic [15:0] o_err_code;
    logic        o_bcast_added;
    logic        o_end_of_packet;

    // parser state as tracked on the testbench side
    t_phase      parse_ph  = PH_OP_HI;
    logic [7:0]  hold_hi   = 8'h00;
    logic [15:0] size_q    = 16'h0000;
    logic [15:0] left_q    = 16'h0000;
    logic [15:0] blk_q     = 16'h0000;
    logic [15:0] code_q    = 16'h0000;
    logic        added_q   = 1'b0;

    t_result     expected_events[$];
    int          err_count    = 0;
    int          bytes_sent   = 0;
    int          quiet_cycles = 0;
    bit          tx_gaps_on   = 1'b0;
    bit          rx_stalls_on = 1'b0;
    bit          hold_long    = 1'b0;

    tftp_packet_deframer u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_rx_byte       (i_rx_byte),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_packet_type   (o_packet_type),
        .o_event_kind    (o_event_kind),
        .o_payload_byte  (o_payload_byte),
        .o_block_number  (o_block_number),
        .o_payload_length(o_payload_length),
        .o_err_code      (o_err_code),
        .o_bcast_added   (o_bcast_added),
        .o_end_of_packet (o_end_of_packet)
    );

    // clock
    always begin
        #CLK_HALF i_clk = 1'b1;
        #CLK_HALF i_clk = 1'b0;
    end

    function automatic t_result pkt_event(input logic [2:0] ptype, input logic kind,
                                          input logic [7:0] data, input logic [15:0] blk,
                                          input logic [15:0] len, input logic [15:0] code,
                                          input logic added, input logic eop);
        t_result r;
        r.has_result     = 1'b1;
        r.packet_type    = ptype;
        r.event_kind     = kind;
        r.payload_byte   = data;
        r.block_number   = blk;
        r.payload_length = len;
        r.err_code       = code;
        r.bcast_added    = added;
        r.end_of_packet  = eop;
        return r;
    endfunction

    // advance the tracked parser by one byte, return the event it causes
    function automatic t_result parse_byte(input logic [7:0] b);
        t_result     r;
        logic [15:0] word;
        r    = '0;
        word = {hold_hi, b};
        case (parse_ph)
            PH_OP_HI: begin
                hold_hi  = b;
                parse_ph = PH_OP_LO;
            end
            PH_OP_LO: begin
                case (word)
                    OP_DATA:  parse_ph = PH_SIZE_HI;
                    OP_ACK:   parse_ph = PH_ABLK_HI;
                    OP_ERROR: parse_ph = PH_CODE_HI;
                    OP_BCAST: parse_ph = PH_FLAG;
                    default: begin
                        parse_ph = PH_OP_HI;
                        r = pkt_event(TYPE_UNKNOWN, EV_DONE, 8'h00, 16'h0, 16'h0, 16'h0,
                                      1'b0, 1'b1);
                    end
                endcase
            end
            PH_SIZE_HI, PH_DBLK_HI, PH_ABLK_HI, PH_CODE_HI: begin
                hold_hi  = b;
                parse_ph = t_phase'(parse_ph + 4'd1);
            end
            PH_SIZE_LO: begin
                size_q   = word;
                parse_ph = PH_DBLK_HI;
            end
            PH_DBLK_LO: begin
                blk_q  = word;
                left_q = size_q;
                if (size_q == 16'h0000) begin
                    parse_ph = PH_OP_HI;
                    r = pkt_event(TYPE_DATA, EV_DONE, 8'h00, blk_q, size_q, 16'h0, 1'b0, 1'b1);
                end else begin
                    parse_ph = PH_PAYLOAD;
                end
            end
            PH_PAYLOAD: begin
                left_q = left_q - 16'd1;
                if (left_q == 16'h0000) begin
                    parse_ph = PH_OP_HI;
                end
                r = pkt_event(TYPE_DATA, EV_BYTE, b, blk_q, size_q, 16'h0, 1'b0,
                              left_q == 16'h0000);
            end
            PH_ABLK_LO: begin
                blk_q    = word;
                parse_ph = PH_OP_HI;
                r = pkt_event(TYPE_ACK, EV_DONE, 8'h00, blk_q, 16'h0, 16'h0, 1'b0, 1'b1);
            end
            PH_CODE_LO: begin
                code_q   = word;
                parse_ph = PH_MSG;
            end
            PH_MSG: begin
                // message text is dropped up to its terminator
                if (b == CHAR_NUL) begin
                    parse_ph = PH_OP_HI;
                    r = pkt_event(TYPE_ERROR, EV_DONE, 8'h00, 16'h0, 16'h0, code_q, 1'b0, 1'b1);
                end
            end
            PH_FLAG: begin
                added_q  = (b == FLAG_ADDED);
                parse_ph = PH_NAME;
            end
            PH_NAME: begin
                if (b != CHAR_NUL) begin
                    r = pkt_event(TYPE_BCAST, EV_BYTE, b, 16'h0, 16'h0, 16'h0, added_q, 1'b0);
                end else begin
                    parse_ph = PH_OP_HI;
                    r = pkt_event(TYPE_BCAST, EV_DONE, 8'h00, 16'h0, 16'h0, 16'h0, added_q, 1'b1);
                end
            end
            default: begin
                parse_ph = PH_OP_HI;
            end
        endcase
        return r;
    endfunction

    task automatic report_error(input string msg);
        err_count++;
        $display("%0t ns: %s", $time, msg);
    endtask

    // track accepted requests, then check each delivered result
    always @(posedge i_clk) begin : result_check
        t_result got_ev;
        t_result want;
        if (i_rst_n && i_valid && o_ready) begin
            got_ev = parse_byte(i_rx_byte);
            if (got_ev.has_result) begin
                expected_events.insert(expected_events.size(), got_ev);
            end
        end
        if (i_rst_n && o_valid && i_ready) begin
            if (expected_events.size() == 0) begin
                report_error($sformatf("unexpected result type %0d kind %0d byte %h",
                                       o_packet_type, o_event_kind, o_payload_byte));
            end else begin
                want = expected_events.pop_front();
                if (o_packet_type !== want.packet_type)
                    report_error($sformatf("packet_type %0d, expected %0d",
                                           o_packet_type, want.packet_type));
                if (o_event_kind !== want.event_kind)
                    report_error($sformatf("event_kind %0d, expected %0d",
                                           o_event_kind, want.event_kind));
                if (o_payload_byte !== want.payload_byte)
                    report_error($sformatf("payload_byte %h, expected %h",
                                           o_payload_byte, want.payload_byte));
                if (o_block_number !== want.block_number)
                    report_error($sformatf("block_number %h, expected %h",
                                           o_block_number, want.block_number));
                if (o_payload_length !== want.payload_length)
                    report_error($sformatf("payload_length %h, expected %h",
                                           o_payload_length, want.payload_length));
                if (o_err_code !== want.err_code)
                    report_error($sformatf("err_code %h, expected %h",
                                           o_err_code, want.err_code));
                if (o_bcast_added !== want.bcast_added)
                    report_error($sformatf("bcast_added %0d, expected %0d",
                                           o_bcast_added, want.bcast_added));
                if (o_end_of_packet !== want.end_of_packet)
                    report_error($sformatf("end_of_packet %0d, expected %0d",
                                           o_end_of_packet, want.end_of_packet));
            end
        end
    end

    // watchdog on cycles with no request moving on either side
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("[tftp_packet_deframer] ERROR");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // result side: random stall bursts and one long hold-off on demand
    initial begin
        forever begin
            @(posedge i_clk);
            if (hold_long) begin
                i_ready <= 1'b0;
                repeat (LONG_STALL) @(posedge i_clk);
                hold_long = 1'b0;
                i_ready <= 1'b1;
            end else if (rx_stalls_on && $urandom_range(0, 5) == 0) begin
                i_ready <= 1'b0;
                repeat ($urandom_range(1, 11)) @(posedge i_clk);
                i_ready <= 1'b1;
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    // offer one byte and wait for its request to be taken; valid stays up
    task automatic send_byte(input logic [7:0] b);
        if (tx_gaps_on && $urandom_range(0, 5) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge i_clk);
        end
        i_valid   <= 1'b1;
        i_rx_byte <= b;
        do @(posedge i_clk); while (!o_ready);
        bytes_sent++;
    endtask

    task automatic send_word(input logic [15:0] w);
        send_byte(w[15:8]);
        send_byte(w[7:0]);
    endtask

    task automatic send_data_packet(input logic [15:0] size, input logic [15:0] blk);
        send_word(OP_DATA);
        send_word(size);
        send_word(blk);
        for (int n = 0; n < size; n++) begin
            send_byte(8'($urandom));
        end
    endtask

    task automatic send_ack(input logic [15:0] blk);
        send_word(OP_ACK);
        send_word(blk);
    endtask

    task automatic send_error(input logic [15:0] code, input int msg_len);
        send_word(OP_ERROR);
        send_word(code);
        repeat (msg_len) send_byte(8'($urandom_range(1, 255)));
        send_byte(CHAR_NUL);
    endtask

    task automatic send_bcast(input logic [7:0] flag, input int name_len);
        send_word(OP_BCAST);
        send_byte(flag);
        repeat (name_len) send_byte(8'($urandom_range(1, 255)));
        send_byte(CHAR_NUL);
    endtask

    // mostly well-formed packets with random content, some unknown opcodes and stray bytes
    task automatic send_random_packet();
        int          pick;
        logic [15:0] op;
        logic [7:0]  flag;
        pick = $urandom_range(0, 99);
        if (pick < 35) begin
            if ($urandom_range(0, 29) == 0)
                send_data_packet(16'($urandom_range(100, 300)), 16'($urandom));
            else
                send_data_packet(16'($urandom_range(0, 10)), 16'($urandom));
        end else if (pick < 50) begin
            send_ack(16'($urandom));
        end else if (pick < 65) begin
            send_error(16'($urandom), $urandom_range(0, 6));
        end else if (pick < 85) begin
            case ($urandom_range(0, 3))
                0:       flag = 8'h00;
                1:       flag = FLAG_ADDED;
                default: flag = 8'($urandom);
            endcase
            send_bcast(flag, $urandom_range(0, 8));
        end else if (pick < 95) begin
            // unknown opcodes, often close to the known ones
            op = ($urandom_range(0, 1) == 0) ? 16'($urandom_range(0, 15)) : 16'($urandom);
            if (op == OP_DATA || op == OP_ACK || op == OP_ERROR || op == OP_BCAST)
                op = op ^ 16'h0100;
            send_word(op);
        end else begin
            repeat ($urandom_range(1, 3)) send_byte(8'($urandom));
        end
    endtask

    task automatic test_unknown_opcode();
        send_word(16'hFFFF);
    endtask

    task automatic test_ack();
        send_ack(16'hFFFF);
    endtask

    task automatic test_data();
        // empty packet completes on the block number
        send_data_packet(16'h0000, 16'h0000);
        // a single byte is also the last one
        send_data_packet(16'h0001, 16'hFFFF);
    endtask

    task automatic test_error();
        send_error(16'h0000, 0);
    endtask

    task automatic test_broadcast();
        send_bcast(FLAG_ADDED, 1);
    endtask

    // size with a nonzero high byte
    task automatic test_wide_size();
        send_data_packet(16'h0100, 16'($urandom));
    endtask

    task automatic test_backpressure();
        tx_gaps_on = 1'b0;
        hold_long  = 1'b1;
        send_data_packet(16'd48, 16'h8001);
    endtask

    task automatic test_random_traffic(input int n_bytes);
        int stop_at;
        stop_at = bytes_sent + n_bytes;
        while (bytes_sent < stop_at) send_random_packet();
    endtask

    task automatic finish_run();
        i_valid <= 1'b0;
        while (expected_events.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (err_count == 0) begin
            $display("[tftp_packet_deframer] OK");
        end else begin
            $display("[tftp_packet_deframer] ERROR");
        end
        $finish;
    endtask

    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        tx_gaps_on   = 1'b1;
        rx_stalls_on = 1'b1;
        test_unknown_opcode();
        test_ack();
        test_data();
        test_error();
        test_broadcast();
        test_backpressure();

        tx_gaps_on = 1'b1;
        test_random_traffic(1100);
        test_wide_size();

        // full rate on both sides to close the run
        tx_gaps_on   = 1'b0;
        rx_stalls_on = 1'b0;
        test_random_traffic(300);
        finish_run();
    end

endmodule

@@ sim.f @@
rtl/tfd_pkg.sv
rtl/tfd_parser.sv
rtl/tftp_packet_deframer.sv
tb/testbench.sv
